// ----- hdl/svdp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse vector dot product package
// Shared types and constants for the merge-join sequencer and its MAC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package svdp_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned AccWidth   = 64;
  localparam int unsigned MatchWidth = 9;

  localparam logic                  CmdEntryA = 1'b0;
  localparam logic                  CmdEntryB = 1'b1;
  localparam logic [MatchWidth-1:0] MatchMax  = 9'd511;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACC,
    ST_DONE
  } svdp_state_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clear;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/sparse_vector_dot_product.sv -----
// An A entry is written to the store at the count. A B entry reads the stored
// A entries from the pointer on, one at a time, until an index is not below its
// own or the entries run out, and takes a saturating accumulate on a match.
// A final B entry also waits for the output register to be free.
// Reset clears the counters, pointer, accumulator and flags at once; the
// entry store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Sparse vector dot product
// Merge join of a stored sparse vector A against a streamed sparse vector B.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_vector_dot_product #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [15:0] entry_index_i,
  input  wire logic [31:0] entry_value_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      dot_product_o,
  output logic [8:0]       match_count_o,
  output logic             saturated_o,
  output logic             capacity_overflow_o
);

  import svdp_pkg::*;

  localparam int unsigned IdxWidth   = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam int unsigned CntWidth   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AddrWidth  = $clog2(MAX_ENTRIES);
  localparam int unsigned EntryWidth = IdxWidth + ValueWidth;
  localparam logic [CntWidth-1:0] CntMax = CntWidth'(MAX_ENTRIES);

  svdp_state_e state_q, state_d;

  logic [CntWidth-1:0]   count_q, count_d;
  logic [CntWidth-1:0]   ptr_q, ptr_d;
  logic [CntWidth-1:0]   ptr_inc;
  logic [MatchWidth-1:0] matches_q, matches_d;
  logic                  ovf_q, ovf_d;

  logic [IdxWidth-1:0]   idx_q, idx_d;
  logic [ValueWidth-1:0] val_q, val_d;
  logic                  last_q, last_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic [AccWidth-1:0]   dot_q;
  logic [MatchWidth-1:0] cnt_q;
  logic                  sat_q;
  logic                  ovfo_q;

  logic                  wr_en;
  logic                  rd_en;
  logic [AddrWidth-1:0]  rd_addr;
  logic [EntryWidth-1:0] rd_data;
  logic [IdxWidth-1:0]   rd_idx;
  logic [AccWidth-1:0]   acc;
  logic                  acc_sat;
  logic                  accept;
  mac_ctrl_t             mac_ctrl;

  assign accept  = in_valid_i && in_ready_o;
  assign ptr_inc = ptr_q + CntWidth'(1);
  assign rd_idx  = rd_data[EntryWidth-1:ValueWidth];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    matches_d   = matches_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    val_d       = val_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = ptr_q[AddrWidth-1:0];
    mac_ctrl    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (command_i == CmdEntryA) begin
            if (count_q < CntMax) begin
              wr_en   = 1'b1;
              count_d = count_q + CntWidth'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            idx_d  = entry_index_i[IdxWidth-1:0];
            val_d  = entry_value_i;
            last_d = last_i;
            if (ptr_q < count_q) begin
              rd_en   = 1'b1;
              state_d = ST_CMP;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_CMP: begin
        if (rd_idx < idx_q) begin
          ptr_d = ptr_inc;
          if (ptr_inc < count_q) begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc[AddrWidth-1:0];
          end else begin
            state_d = ST_DONE;
          end
        end else if (rd_idx == idx_q) begin
          mac_ctrl.mul_en = 1'b1;
          ptr_d           = ptr_inc;
          if (matches_q < MatchMax) begin
            matches_d = matches_q + MatchWidth'(1);
          end
          state_d = ST_ACC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_load       = 1'b1;
          out_valid_d    = 1'b1;
          mac_ctrl.clear = 1'b1;
          count_d        = '0;
          ptr_d          = '0;
          matches_d      = '0;
          ovf_d          = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      matches_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      matches_q   <= matches_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    val_q  <= val_d;
    last_q <= last_d;
    if (out_load) begin
      dot_q  <= acc;
      cnt_q  <= matches_q;
      sat_q  <= acc_sat;
      ovfo_q <= ovf_q;
    end
  end

  svdp_store #(
    .Depth (MAX_ENTRIES),
    .Width (EntryWidth)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrWidth-1:0]),
    .wr_data_i ({entry_index_i[IdxWidth-1:0], entry_value_i}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  svdp_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .a_value_i (rd_data[ValueWidth-1:0]),
    .b_value_i (val_q),
    .acc_o     (acc),
    .sat_o     (acc_sat)
  );

  assign out_valid_o         = out_valid_q;
  assign dot_product_o       = dot_q;
  assign match_count_o       = cnt_q;
  assign saturated_o         = sat_q;
  assign capacity_overflow_o = ovfo_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("stored entry count exceeds capacity");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= count_q) else $error("read pointer passed stored entry count");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == CntMax) else $error("overflow flag set with free store space");

  a_acc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |=> state_q == ST_DONE) else $error("accumulate not followed by done");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && count_q == '0 && ptr_q == '0)
    else $error("result request not issued or run state not cleared");
`endif

endmodule

`default_nettype wire

// ----- hdl/svdp_store.sv -----
// ----------------------------------------------------------------------------
// Sparse vector dot product entry store
// Single-port-write, single-port-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module svdp_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 48,
  localparam int unsigned AddrWidth = $clog2(Depth)
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AddrWidth-1:0] wr_addr_i,
  input  wire logic [Width-1:0]     wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AddrWidth-1:0] rd_addr_i,
  output logic      [Width-1:0]     rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/svdp_mac.sv -----
// ----------------------------------------------------------------------------
// Sparse vector dot product multiply-accumulate unit
// Registered signed Q16.16 product followed by a saturating Q32.32 accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module svdp_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire svdp_pkg::mac_ctrl_t                 ctrl_i,
  input  wire logic [svdp_pkg::ValueWidth-1:0]     a_value_i,
  input  wire logic [svdp_pkg::ValueWidth-1:0]     b_value_i,
  output logic      [svdp_pkg::AccWidth-1:0]       acc_o,
  output logic                                     sat_o
);

  import svdp_pkg::*;

  localparam logic [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  logic signed [AccWidth-1:0] prod_q;
  logic        [AccWidth-1:0] acc_q, acc_d;
  logic                       sat_q, sat_d;
  logic        [AccWidth:0]   sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= $signed(a_value_i) * $signed(b_value_i);
    end
  end

  always_comb begin
    sum   = {acc_q[AccWidth-1], acc_q} + {prod_q[AccWidth-1], prod_q};
    acc_d = acc_q;
    sat_d = sat_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
      sat_d = 1'b0;
    end else if (ctrl_i.acc_en) begin
      if (sum[AccWidth] != sum[AccWidth-1]) begin
        acc_d = sum[AccWidth] ? AccMin : AccMax;
        sat_d = 1'b1;
      end else begin
        acc_d = sum[AccWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

// ----- bench/tb_sparse_vector_dot_product.sv -----
// ----------------------------------------------------------------------------
// Sparse vector dot product testbench
// Streams pairs of sparse vectors through the merge-join block and checks
// every result against a predictor that keeps its own entry store, pointer,
// saturating accumulator and flags. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------

module tb_sparse_vector_dot_product;

  import svdp_pkg::*;

  localparam int StoreDepth = 256;

  typedef struct packed {
    logic        cmd;
    logic [15:0] idx;
    logic [31:0] val;
    logic        lst;
  } entry_req_t;

  typedef struct packed {
    logic [63:0] dot;
    logic [8:0]  cnt;
    logic        sat;
    logic        ovf;
  } dot_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        command_i     = CmdEntryA;
  logic [15:0] entry_index_i = '0;
  logic [31:0] entry_value_i = '0;
  logic        last_i        = 1'b0;
  logic        out_ready_i   = 1'b1;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [63:0] dot_product_o;
  logic [8:0]  match_count_o;
  logic        saturated_o;
  logic        capacity_overflow_o;

  // Predictor state.
  logic [15:0] store_idx [StoreDepth];
  logic [31:0] store_val [StoreDepth];
  int          store_count;
  int          join_ptr;
  logic [63:0] run_sum;
  logic [8:0]  match_total;
  logic        run_sat;
  logic        store_ovf;

  dot_result_t expected_results[$];
  int          error_count = 0;
  int          sent_items  = 0;
  bit          idle_en     = 1'b1;

  sparse_vector_dot_product i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .command_i           (command_i),
    .entry_index_i       (entry_index_i),
    .entry_value_i       (entry_value_i),
    .last_i              (last_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .dot_product_o       (dot_product_o),
    .match_count_o       (match_count_o),
    .saturated_o         (saturated_o),
    .capacity_overflow_o (capacity_overflow_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_pair_state();
    store_count = 0;
    join_ptr    = 0;
    run_sum     = '0;
    match_total = '0;
    run_sat     = 1'b0;
    store_ovf   = 1'b0;
  endfunction

  function automatic bit merge_join_predict(input logic cmd, input logic [15:0] idx,
                                            input logic [31:0] val, input logic lst,
                                            output dot_result_t res);
    longint      prod;
    logic [64:0] wide_sum;
    res = '0;
    if (cmd == CmdEntryA) begin
      if (store_count < StoreDepth) begin
        store_idx[store_count] = idx;
        store_val[store_count] = val;
        store_count++;
      end else begin
        store_ovf = 1'b1;
      end
      return 1'b0;
    end
    while (join_ptr < store_count && store_idx[join_ptr] < idx) join_ptr++;
    if (join_ptr < store_count && store_idx[join_ptr] == idx) begin
      prod = longint'($signed(store_val[join_ptr])) * longint'($signed(val));
      wide_sum = {run_sum[63], run_sum} + {prod[63], prod};
      if (wide_sum[64] != wide_sum[63]) begin
        run_sum = wide_sum[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        run_sat = 1'b1;
      end else begin
        run_sum = wide_sum[63:0];
      end
      if (match_total < MatchMax) match_total++;
      join_ptr++;
    end
    if (!lst) return 1'b0;
    res.dot = run_sum;
    res.cnt = match_total;
    res.sat = run_sat;
    res.ovf = store_ovf;
    clear_pair_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic send_request(input logic cmd, input logic [15:0] idx,
                              input logic [31:0] val, input logic lst);
    dot_result_t res;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    entry_index_i <= idx;
    entry_value_i <= val;
    last_i        <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    if (merge_join_predict(cmd, idx, val, lst, res))
      expected_results.insert(expected_results.size(), res);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  function automatic logic [31:0] rand_value(input bit extreme);
    if (!extreme) return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return 32'h0001_0000;
    endcase
  endfunction

  task automatic send_vector_pair(input bit noisy);
    entry_req_t a_list[$];
    entry_req_t b_list[$];
    entry_req_t e;
    int         n;
    int         idx;
    int         step_max;
    int         k;
    int         pick;
    logic [15:0] tmp;
    bit         extreme;
    n        = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    step_max = $urandom_range(0, 1) ? 4 : 6000;
    idx      = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 65535);
    extreme  = ($urandom_range(0, 5) == 0);
    for (k = 0; k < n && idx <= 65535; k++) begin
      pick = $urandom_range(0, 2);
      if (pick != 1)
        a_list.insert(a_list.size(), {CmdEntryA, idx[15:0], rand_value(extreme), 1'b0});
      if (pick != 0)
        b_list.insert(b_list.size(), {CmdEntryB, idx[15:0], rand_value(extreme), 1'b0});
      idx += $urandom_range(1, step_max);
    end
    if (b_list.size() == 0) begin
      tmp = $urandom;
      b_list.insert(b_list.size(), {CmdEntryB, tmp, rand_value(extreme), 1'b0});
    end
    if (a_list.size() != 0) a_list[a_list.size()-1].lst = 1'b1;
    b_list[b_list.size()-1].lst = 1'b1;
    if (noisy) begin
      case ($urandom_range(0, 3))
        0: if (b_list.size() >= 2) begin
          tmp = b_list[0].idx;
          b_list[0].idx = b_list[1].idx;
          b_list[1].idx = tmp;
        end
        1: if (a_list.size() >= 2) begin
          tmp = a_list[0].idx;
          a_list[0].idx = a_list[1].idx;
          a_list[1].idx = tmp;
        end
        2: foreach (a_list[j]) a_list[j].lst = $urandom_range(0, 1);
        default: if (a_list.size() != 0) begin
          e = a_list.pop_back();
          b_list.insert(1, e);
        end
      endcase
    end
    foreach (a_list[j]) send_request(a_list[j].cmd, a_list[j].idx, a_list[j].val, a_list[j].lst);
    foreach (b_list[j]) send_request(b_list[j].cmd, b_list[j].idx, b_list[j].val, b_list[j].lst);
  endtask

  task automatic test_directed_cases();
    // An empty A vector gives a zero sum.
    send_request(CmdEntryB, 16'd7, 32'h0001_0000, 1'b1);
    // Index and value extremes; the last flag on an A entry is ignored.
    send_request(CmdEntryA, 16'd0, 32'h7fff_ffff, 1'b0);
    send_request(CmdEntryA, 16'hffff, 32'h8000_0000, 1'b1);
    send_request(CmdEntryB, 16'd0, 32'h7fff_ffff, 1'b0);
    send_request(CmdEntryB, 16'hffff, 32'h8000_0000, 1'b1);
    // Positive saturation.
    send_request(CmdEntryA, 16'd1, 32'h8000_0000, 1'b0);
    send_request(CmdEntryA, 16'd2, 32'h8000_0000, 1'b1);
    send_request(CmdEntryB, 16'd1, 32'h8000_0000, 1'b0);
    send_request(CmdEntryB, 16'd2, 32'h8000_0000, 1'b1);
    // Negative saturation.
    send_request(CmdEntryA, 16'd3, 32'h8000_0000, 1'b0);
    send_request(CmdEntryA, 16'd4, 32'h8000_0000, 1'b0);
    send_request(CmdEntryA, 16'd5, 32'h8000_0000, 1'b1);
    send_request(CmdEntryB, 16'd3, 32'h7fff_ffff, 1'b0);
    send_request(CmdEntryB, 16'd4, 32'h7fff_ffff, 1'b0);
    send_request(CmdEntryB, 16'd5, 32'h7fff_ffff, 1'b1);
    // B indices out of order fail to match once the pointer has passed.
    send_request(CmdEntryA, 16'd5, 32'h0002_0000, 1'b0);
    send_request(CmdEntryA, 16'd10, 32'hfffe_0000, 1'b1);
    send_request(CmdEntryB, 16'd10, 32'h0003_0000, 1'b0);
    send_request(CmdEntryB, 16'd5, 32'h0004_0000, 1'b0);
    send_request(CmdEntryB, 16'd10, 32'h0005_0000, 1'b1);
    // An A entry arriving between B entries is appended.
    send_request(CmdEntryA, 16'd4, 32'h0001_8000, 1'b0);
    send_request(CmdEntryB, 16'd4, 32'hffff_8000, 1'b0);
    send_request(CmdEntryA, 16'd8, 32'h1234_5678, 1'b1);
    send_request(CmdEntryB, 16'd8, 32'h8765_4321, 1'b1);
  endtask

  task automatic test_store_capacity();
    int k;
    // A full store with every entry matched.
    for (k = 0; k < StoreDepth; k++)
      send_request(CmdEntryA, 16'(k * 3), $urandom, k == StoreDepth - 1);
    for (k = 0; k < StoreDepth; k++)
      send_request(CmdEntryB, 16'(k * 3), $urandom, k == StoreDepth - 1);
    // Entries past the store size are dropped and flagged.
    for (k = 0; k < StoreDepth + 4; k++)
      send_request(CmdEntryA, 16'(k), $urandom, k == StoreDepth + 3);
    send_request(CmdEntryB, 16'd100, $urandom, 1'b0);
    send_request(CmdEntryB, 16'd255, $urandom, 1'b0);
    send_request(CmdEntryB, 16'd259, $urandom, 1'b1);
  endtask

  task automatic test_random_vectors(input int count);
    int stop_at;
    bit drained;
    stop_at = sent_items + count;
    drained = 1'b0;
    while (sent_items < stop_at) begin
      send_vector_pair($urandom_range(0, 4) == 0);
      if (!drained && sent_items >= stop_at - count / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_vectors(300);
  endtask

  always @(posedge clk_i) begin : result_check
    dot_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (dot_product_o !== want.dot)
          report_mismatch($sformatf("dot_product %h, expected %h", dot_product_o, want.dot));
        if (match_count_o !== want.cnt)
          report_mismatch($sformatf("match_count %0d, expected %0d", match_count_o, want.cnt));
        if (saturated_o !== want.sat)
          report_mismatch($sformatf("saturated %b, expected %b", saturated_o, want.sat));
        if (capacity_overflow_o !== want.ovf)
          report_mismatch($sformatf("capacity_overflow %b, expected %b",
                                    capacity_overflow_o, want.ovf));
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 18)) @(posedge clk_i);
    end
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clear_pair_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_store_capacity();
    test_random_vectors(450);
    test_back_to_back();
    wait_for_results();
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
